// ===== hdl/dcpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpc_pkg
// Shared types and codes of the sorted distinct color set.
// ----------------------------------------------------------------------------
package dcpc_pkg;

  localparam int KEY_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int IDX_W   = 8;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 9;

  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_ADDED       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP         = 3'd1;
  localparam logic [STAT_W-1:0] ST_TRANSPARENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_OK     = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX   = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED     = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              eval_en;
    logic              insert_en;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  rd_idx;
  } cell_ctrl_t;

endpackage

// ===== hdl/dcpc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpc_in_if
// Request channel: pixel, read or clear requests.
// ----------------------------------------------------------------------------
interface dcpc_in_if;
  logic                            valid;
  logic                            ready;
  logic [dcpc_pkg::KIND_W-1:0]     kind;
  logic [dcpc_pkg::CHAN_W-1:0]     red;
  logic [dcpc_pkg::CHAN_W-1:0]     green;
  logic [dcpc_pkg::CHAN_W-1:0]     blue;
  logic [dcpc_pkg::CHAN_W-1:0]     alpha;
  logic [dcpc_pkg::IDX_W-1:0]      entry_index;

  modport source (output valid, kind, red, green, blue, alpha, entry_index, input ready);
  modport sink   (input valid, kind, red, green, blue, alpha, entry_index, output ready);
endinterface

// ===== hdl/dcpc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpc_out_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface dcpc_out_if;
  logic                            valid;
  logic                            ready;
  logic [dcpc_pkg::STAT_W-1:0]     status;
  logic [dcpc_pkg::COUNT_W-1:0]    color_count;
  logic [dcpc_pkg::CHAN_W-1:0]     entry_red;
  logic [dcpc_pkg::CHAN_W-1:0]     entry_green;
  logic [dcpc_pkg::CHAN_W-1:0]     entry_blue;

  modport source (output valid, status, color_count, entry_red, entry_green, entry_blue,
                  input ready);
  modport sink   (input valid, status, color_count, entry_red, entry_green, entry_blue,
                  output ready);
endinterface

// ===== hdl/dcpc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpc_cell
// One slot of the sorted chain: holds a key, compares it against the
// broadcast key and takes the new key or its left neighbor's on insert.
// ----------------------------------------------------------------------------
module dcpc_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  dcpc_pkg::cell_ctrl_t         ctrl,
  input  logic                         occupied,
  input  logic                         left_lt,
  input  logic [dcpc_pkg::KEY_W-1:0]   left_key,
  output logic                         lt_o,
  output logic                         eq_o,
  output logic [dcpc_pkg::KEY_W-1:0]   key_o,
  output logic [dcpc_pkg::KEY_W-1:0]   rd_data_o
);

  logic [dcpc_pkg::KEY_W-1:0] key_r;
  logic                       lt_r;
  logic                       eq_r;
  logic                       sel_r;

  always_ff @(posedge clk) begin
    if (ctrl.eval_en) begin
      lt_r  <= occupied && (key_r < ctrl.key);
      eq_r  <= occupied && (key_r == ctrl.key);
      sel_r <= (IDX == int'(ctrl.rd_idx));
    end
    if (ctrl.insert_en && !lt_r) begin
      key_r <= left_lt ? ctrl.key : left_key;
    end
  end

  assign lt_o      = lt_r;
  assign eq_o      = eq_r;
  assign key_o     = key_r;
  assign rd_data_o = sel_r ? key_r : '0;

endmodule

// ===== hdl/distinct_color_palette_collector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_color_palette_collector_unit
// Sorted set of distinct opaque RGB colors held in a chain of cells.
// ----------------------------------------------------------------------------
// in_ch carries requests: pixel (kind 0), read sorted entry (kind 1) or
// clear (kind 2). out_ch returns exactly one result per request, in order,
// with the status, the color count after the request and, for a good read,
// the entry's color.
// A request is taken when in_ch.valid and in_ch.ready are high. In the
// cycle after, every cell has registered its compare against the new key;
// the duplicate check, the insert shift and the read select complete in
// the EVAL state, once the output register is free, and load the output
// register. A request thus passes the compare stage in the cells and then
// the commit; the result is registered, and in_ch.ready stays low until the
// commit, so a new request is taken only once the last one is committed.
// A held result waits in the output register while the next request is
// taken; the commit of that request waits until out_ch.ready frees it.
// Synchronous reset (rst_n low) empties the set and drops any result.
// ----------------------------------------------------------------------------
module distinct_color_palette_collector_unit #(
  parameter int CAPACITY = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  dcpc_in_if.sink  in_ch,
  dcpc_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = dcpc_pkg::KEY_W;

  dcpc_pkg::state_t            state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [dcpc_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [KW-1:0]               entry_r, entry_nxt;
  logic [dcpc_pkg::COUNT_W-1:0] ocount_r, ocount_nxt;

  logic [dcpc_pkg::KIND_W-1:0] kind_r;
  logic                        opaque_r;
  logic [dcpc_pkg::IDX_W-1:0]  idx_r;
  logic [KW-1:0]               key_r;

  dcpc_pkg::cell_ctrl_t        ctrl;
  logic [CAPACITY-1:0]         occ;
  logic [CAPACITY-1:0]         lt_vec;
  logic [CAPACITY-1:0]         eq_vec;
  logic [KW-1:0]               keys   [CAPACITY];
  logic [KW-1:0]               rdata  [CAPACITY];
  logic [KW-1:0]               rd_or;

  logic accept;
  logic commit;
  logic any_dup;
  logic is_full;
  logic do_insert;
  logic rd_ok;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == dcpc_pkg::S_IDLE);
  assign commit  = (state_r == dcpc_pkg::S_EVAL) && (!out_valid_r || out_ch.ready);
  assign any_dup = |eq_vec;
  assign is_full = (32'(count_r) >= CAPACITY);
  assign do_insert = commit && (kind_r == dcpc_pkg::KIND_PIXEL) && opaque_r &&
                     !any_dup && !is_full;
  assign rd_ok   = (32'(idx_r) < 32'(count_r));

  assign ctrl.eval_en   = accept;
  assign ctrl.insert_en = do_insert;
  assign ctrl.key       = accept ? {in_ch.red, in_ch.green, in_ch.blue} : key_r;
  assign ctrl.rd_idx    = in_ch.entry_index;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (CW'(gi) < count_r);
      if (gi == 0) begin : g_head
        dcpc_cell #(.IDX(gi)) u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occ[gi]),
          .left_lt   (1'b1),
          .left_key  ({KW{1'b0}}),
          .lt_o      (lt_vec[gi]),
          .eq_o      (eq_vec[gi]),
          .key_o     (keys[gi]),
          .rd_data_o (rdata[gi])
        );
      end else begin : g_body
        dcpc_cell #(.IDX(gi)) u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occ[gi]),
          .left_lt   (lt_vec[gi-1]),
          .left_key  (keys[gi-1]),
          .lt_o      (lt_vec[gi]),
          .eq_o      (eq_vec[gi]),
          .key_o     (keys[gi]),
          .rd_data_o (rdata[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rdata[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_ch.kind;
      opaque_r <= (in_ch.alpha != '0);
      idx_r    <= in_ch.entry_index;
      key_r    <= {in_ch.red, in_ch.green, in_ch.blue};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    ocount_nxt    = ocount_r;
    case (state_r)
      dcpc_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = dcpc_pkg::S_EVAL;
        end
      end
      dcpc_pkg::S_EVAL: begin
        if (commit) begin
          entry_nxt = '0;
          case (kind_r)
            dcpc_pkg::KIND_PIXEL: begin
              if (!opaque_r) begin
                status_nxt = dcpc_pkg::ST_TRANSPARENT;
              end else if (any_dup) begin
                status_nxt = dcpc_pkg::ST_DUP;
              end else if (is_full) begin
                status_nxt = dcpc_pkg::ST_FULL;
              end else begin
                status_nxt = dcpc_pkg::ST_ADDED;
                count_nxt  = count_r + 1'b1;
              end
            end
            dcpc_pkg::KIND_READ: begin
              if (rd_ok) begin
                status_nxt = dcpc_pkg::ST_READ_OK;
                entry_nxt  = rd_or;
              end else begin
                status_nxt = dcpc_pkg::ST_BAD_INDEX;
              end
            end
            dcpc_pkg::KIND_CLEAR: begin
              status_nxt = dcpc_pkg::ST_CLEARED;
              count_nxt  = '0;
            end
            default: begin
              status_nxt = dcpc_pkg::ST_BAD_INDEX;
            end
          endcase
          ocount_nxt    = dcpc_pkg::COUNT_W'(count_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = dcpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dcpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcpc_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    ocount_r <= ocount_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.color_count = ocount_r;
  assign out_ch.entry_red   = entry_r[23:16];
  assign out_ch.entry_green = entry_r[15:8];
  assign out_ch.entry_blue  = entry_r[7:0];

`ifndef SYNTHESIS
  a_dup_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcpc_pkg::S_EVAL) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not raise count");

  a_no_take_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcpc_pkg::S_EVAL) |-> !in_ch.ready)
    else $error("request taken during commit");

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit without result");
`endif

endmodule
